/* hw/rtl/rac_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rac_pkg
// shared types, codes and arithmetic helpers of the radial attraction block
// ----------------------------------------------------------------------------
package rac_pkg;

    localparam int FRAC_BITS = 16;
    localparam int NUM_W     = 32 + FRAC_BITS;   // scaled dividend width
    localparam int QUO_W     = NUM_W + 1;        // signed quotient width

    typedef struct packed {
        logic signed [31:0] body_x;
        logic signed [31:0] body_y;
        logic signed [31:0] source_x;
        logic signed [31:0] source_y;
        logic signed [31:0] coef_constant;
        logic signed [31:0] coef_linear;
        logic signed [31:0] coef_square;
        logic               source_present;
        logic               last_source;
    } t_in;

    typedef struct packed {
        logic signed [31:0] force_x;
        logic signed [31:0] force_y;
        logic               significant;
        logic               saturated;
    } t_out;

    // datapath operations
    localparam logic [4:0] OP_NONE    = 5'd0;
    localparam logic [4:0] OP_LOAD    = 5'd1;
    localparam logic [4:0] OP_SQX     = 5'd2;
    localparam logic [4:0] OP_SQY     = 5'd3;
    localparam logic [4:0] OP_LEN2    = 5'd4;
    localparam logic [4:0] OP_SQRT_GO = 5'd5;
    localparam logic [4:0] OP_DSET    = 5'd6;
    localparam logic [4:0] OP_DIV_GO  = 5'd7;
    localparam logic [4:0] OP_DIV_WB  = 5'd8;
    localparam logic [4:0] OP_GAIN    = 5'd9;
    localparam logic [4:0] OP_MULX    = 5'd10;
    localparam logic [4:0] OP_MULY    = 5'd11;
    localparam logic [4:0] OP_ACCY    = 5'd12;
    localparam logic [4:0] OP_FSAT    = 5'd13;
    localparam logic [4:0] OP_FSQX    = 5'd14;
    localparam logic [4:0] OP_FSQY    = 5'd15;
    localparam logic [4:0] OP_EMIT    = 5'd16;

    // division jobs
    localparam logic [2:0] DIV_UX = 3'd0;
    localparam logic [2:0] DIV_UY = 3'd1;
    localparam logic [2:0] DIV_TL = 3'd2;
    localparam logic [2:0] DIV_Q  = 3'd3;
    localparam logic [2:0] DIV_TS = 3'd4;

    // configuration register indexes
    localparam logic REG_MIN_DIST  = 1'b0;
    localparam logic REG_THRESHOLD = 1'b1;

    typedef struct packed {
        logic [4:0] op;
        logic [2:0] div_sel;
    } t_cmd;

    typedef struct packed {
        logic len2_zero;
        logic sqrt_done;
        logic div_done;
        logic out_free;
    } t_sts;

    typedef struct packed {
        logic               clip;
        logic signed [31:0] val;
    } t_sat32;

    typedef struct packed {
        logic               clip;
        logic signed [39:0] val;
    } t_sat40;

    function automatic t_sat32 sat_to32(input logic signed [65:0] v);
        t_sat32 r;
        if (v > 66'sd2147483647) begin
            r.clip = 1'b1;
            r.val  = 32'sh7FFFFFFF;
        end else if (v < -66'sd2147483648) begin
            r.clip = 1'b1;
            r.val  = 32'sh80000000;
        end else begin
            r.clip = 1'b0;
            r.val  = v[31:0];
        end
        return r;
    endfunction

    function automatic t_sat40 sat_to40(input logic signed [65:0] v);
        t_sat40 r;
        if (v > 66'sd549755813887) begin
            r.clip = 1'b1;
            r.val  = 40'sh7FFFFFFFFF;
        end else if (v < -66'sd549755813888) begin
            r.clip = 1'b1;
            r.val  = 40'sh8000000000;
        end else begin
            r.clip = 1'b0;
            r.val  = v[39:0];
        end
        return r;
    endfunction

    // arithmetic shift right by the fraction width, rounding toward zero
    function automatic logic signed [63:0] shr_frac(input logic signed [63:0] p);
        logic signed [63:0] t;
        t = p;
        if (p < 0) begin
            t = p + ((64'sd1 <<< FRAC_BITS) - 64'sd1);
        end
        return t >>> FRAC_BITS;
    endfunction

endpackage

/* hw/rtl/rac_sqrt.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rac_sqrt
// floor square root of a 64-bit unsigned value, one result bit a cycle
// ----------------------------------------------------------------------------
module rac_sqrt import rac_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_n,
    output logic        o_done,
    output logic [31:0] o_root
);

    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [4:0]  r_cnt, n_cnt;
    logic [35:0] r_rem, n_rem;
    logic [31:0] r_root, n_root;
    logic [63:0] r_n, n_n;
    logic [35:0] w_rem;
    logic [35:0] w_trial;

    assign w_rem   = {r_rem[33:0], r_n[63:62]};
    assign w_trial = {2'b00, r_root, 2'b01};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_root = r_root;
        n_n    = r_n;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = 5'd31;
            n_rem  = '0;
            n_root = '0;
            n_n    = i_n;
        end else if (r_busy) begin
            n_n = {r_n[61:0], 2'b00};
            if (w_rem >= w_trial) begin
                n_rem  = w_rem - w_trial;
                n_root = {r_root[30:0], 1'b1};
            end else begin
                n_rem  = w_rem;
                n_root = {r_root[30:0], 1'b0};
            end
            n_cnt = r_cnt - 5'd1;
            if (r_cnt == 5'd0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt  <= n_cnt;
        r_rem  <= n_rem;
        r_root <= n_root;
        r_n    <= n_n;
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

/* hw/rtl/rac_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rac_div
// signed by unsigned restoring divider, truncating, one quotient bit a cycle
// ----------------------------------------------------------------------------
module rac_div import rac_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [NUM_W-1:0] i_num,
    input  logic [31:0]             i_den,
    output logic                    o_done,
    output logic signed [QUO_W-1:0] o_quo
);

    localparam int CNT_W = $clog2(NUM_W);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [31:0]      r_rem, n_rem;
    logic [NUM_W-1:0] r_q, n_q;
    logic [31:0]      r_den, n_den;
    logic             r_neg, n_neg;
    logic [32:0]      w_rem;
    logic [NUM_W:0]   w_mag;

    assign w_rem = {r_rem, r_q[NUM_W-1]};
    // magnitude of the dividend, one bit wider so the most negative value fits
    assign w_mag = i_num[NUM_W-1] ? -{i_num[NUM_W-1], i_num} : {1'b0, i_num};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_q    = r_q;
        n_den  = r_den;
        n_neg  = r_neg;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(NUM_W - 1);
            n_rem  = '0;
            n_q    = w_mag[NUM_W-1:0];
            n_den  = i_den;
            n_neg  = i_num[NUM_W-1];
        end else if (r_busy) begin
            if (w_rem >= {1'b0, r_den}) begin
                n_rem = 32'(w_rem - {1'b0, r_den});
                n_q   = {r_q[NUM_W-2:0], 1'b1};
            end else begin
                n_rem = w_rem[31:0];
                n_q   = {r_q[NUM_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_rem <= n_rem;
        r_q   <= n_q;
        r_den <= n_den;
        r_neg <= n_neg;
    end

    assign o_done = r_done;
    assign o_quo  = r_neg ? -$signed({1'b0, r_q}) : $signed({1'b0, r_q});

endmodule

/* hw/rtl/rac_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rac_ctrl
// sequencer: one datapath op a cycle unless waiting on input, a unit or output
// ----------------------------------------------------------------------------
module rac_ctrl import rac_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_present,
    input  logic i_last,
    input  t_sts i_sts,
    output logic o_in_ready,
    output t_cmd o_cmd
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SQX  = 4'd1;
    localparam logic [3:0] S_SQY  = 4'd2;
    localparam logic [3:0] S_LEN2 = 4'd3;
    localparam logic [3:0] S_CHK  = 4'd4;
    localparam logic [3:0] S_SQRT = 4'd5;
    localparam logic [3:0] S_DGO  = 4'd6;
    localparam logic [3:0] S_DWT  = 4'd7;
    localparam logic [3:0] S_GAIN = 4'd8;
    localparam logic [3:0] S_MULX = 4'd9;
    localparam logic [3:0] S_MULY = 4'd10;
    localparam logic [3:0] S_ACCY = 4'd11;
    localparam logic [3:0] S_FSAT = 4'd12;
    localparam logic [3:0] S_FSQX = 4'd13;
    localparam logic [3:0] S_FSQY = 4'd14;
    localparam logic [3:0] S_EMIT = 4'd15;

    logic [3:0] r_state, n_state;
    logic       r_last, n_last;
    logic [2:0] r_job, n_job;
    logic [3:0] w_end;

    // after a source: finish the set or wait for the next transaction
    assign w_end = r_last ? S_FSAT : S_IDLE;

    always_comb begin
        n_state       = r_state;
        n_last        = r_last;
        n_job         = r_job;
        o_cmd.op      = OP_NONE;
        o_cmd.div_sel = r_job;
        o_in_ready    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_last   = i_last;
                    if (i_present) begin
                        n_state = S_SQX;
                    end else if (i_last) begin
                        n_state = S_FSAT;
                    end
                end
            end
            S_SQX:  begin o_cmd.op = OP_SQX;  n_state = S_SQY;  end
            S_SQY:  begin o_cmd.op = OP_SQY;  n_state = S_LEN2; end
            S_LEN2: begin o_cmd.op = OP_LEN2; n_state = S_CHK;  end
            S_CHK: begin
                if (i_sts.len2_zero) begin
                    n_state = w_end;
                end else begin
                    o_cmd.op = OP_SQRT_GO;
                    n_state  = S_SQRT;
                end
            end
            S_SQRT: begin
                if (i_sts.sqrt_done) begin
                    o_cmd.op = OP_DSET;
                    n_job    = DIV_UX;
                    n_state  = S_DGO;
                end
            end
            S_DGO: begin o_cmd.op = OP_DIV_GO; n_state = S_DWT; end
            S_DWT: begin
                if (i_sts.div_done) begin
                    o_cmd.op = OP_DIV_WB;
                    if (r_job == DIV_TS) begin
                        n_state = S_GAIN;
                    end else begin
                        n_job   = r_job + 3'd1;
                        n_state = S_DGO;
                    end
                end
            end
            S_GAIN: begin o_cmd.op = OP_GAIN; n_state = S_MULX; end
            S_MULX: begin o_cmd.op = OP_MULX; n_state = S_MULY; end
            S_MULY: begin o_cmd.op = OP_MULY; n_state = S_ACCY; end
            S_ACCY: begin o_cmd.op = OP_ACCY; n_state = w_end;  end
            S_FSAT: begin o_cmd.op = OP_FSAT; n_state = S_FSQX; end
            S_FSQX: begin o_cmd.op = OP_FSQX; n_state = S_FSQY; end
            S_FSQY: begin o_cmd.op = OP_FSQY; n_state = S_EMIT; end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.op = OP_EMIT;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_last  <= 1'b0;
            r_job   <= DIV_UX;
        end else begin
            r_state <= n_state;
            r_last  <= n_last;
            r_job   <= n_job;
        end
    end

endmodule

/* hw/rtl/rac_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rac_dp
// datapath: registers, shared multiplier, square root and divider units
// ----------------------------------------------------------------------------
module rac_dp import rac_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_in         i_in_data,
    input  t_cmd        i_cmd,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  logic        i_out_ready,
    output t_sts        o_sts,
    output logic        o_out_valid,
    output t_out        o_out_data
);

    logic [30:0]        r_min_dist;
    logic [31:0]        r_thr;
    logic signed [31:0] r_dx, r_dy, r_cc, r_cl, r_cs;
    logic [63:0]        r_len2;
    logic signed [63:0] r_prod;
    logic [31:0]        r_len, r_d;
    logic signed [31:0] r_ux, r_uy, r_tl, r_q, r_ts, r_g, r_fx, r_fy;
    logic signed [39:0] r_sum_x, r_sum_y;
    logic               r_clip;
    logic               r_out_valid;
    t_out               r_out;

    logic signed [31:0]       w_ma, w_mb;
    logic signed [63:0]       w_prod;
    t_sat32                   w_sdx, w_sdy, w_sq, w_gain, w_sfx, w_sfy;
    t_sat40                   w_acc;
    logic signed [39:0]       w_acc_base;
    logic [31:0]              w_md;
    logic [31:0]              w_root;
    logic                     w_sqrt_done;
    logic signed [NUM_W-1:0]  w_num;
    logic [31:0]              w_den;
    logic signed [QUO_W-1:0]  w_quo;
    logic                     w_div_done;
    logic [63:0]              w_mag;

    // planar difference, source minus body
    assign w_sdx = sat_to32(66'(i_in_data.source_x) - 66'(i_in_data.body_x));
    assign w_sdy = sat_to32(66'(i_in_data.source_y) - 66'(i_in_data.body_y));

    // shared multiplier operand select
    always_comb begin
        w_ma = r_dx;
        w_mb = r_dx;
        case (i_cmd.op)
            OP_SQY:  begin w_ma = r_dy; w_mb = r_dy; end
            OP_MULX: begin w_ma = r_g;  w_mb = r_ux; end
            OP_MULY: begin w_ma = r_g;  w_mb = r_uy; end
            OP_FSQX: begin w_ma = r_fx; w_mb = r_fx; end
            OP_FSQY: begin w_ma = r_fy; w_mb = r_fy; end
            default: ;
        endcase
    end
    assign w_prod = w_ma * w_mb;

    // divider job select
    always_comb begin
        w_num = {r_dx, {FRAC_BITS{1'b0}}};
        w_den = r_d;
        case (i_cmd.div_sel)
            DIV_UX:  begin w_num = {r_dx, {FRAC_BITS{1'b0}}}; w_den = r_len; end
            DIV_UY:  begin w_num = {r_dy, {FRAC_BITS{1'b0}}}; w_den = r_len; end
            DIV_TL:  w_num = {r_cl, {FRAC_BITS{1'b0}}};
            DIV_Q:   w_num = {r_cs, {FRAC_BITS{1'b0}}};
            DIV_TS:  w_num = {r_q,  {FRAC_BITS{1'b0}}};
            default: ;
        endcase
    end

    rac_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.op == OP_SQRT_GO),
        .i_n     (r_len2),
        .o_done  (w_sqrt_done),
        .o_root  (w_root)
    );

    rac_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.op == OP_DIV_GO),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    assign w_md       = (r_min_dist == '0) ? 32'd1 : {1'b0, r_min_dist};
    assign w_sq       = sat_to32(66'(w_quo));
    assign w_gain     = sat_to32(66'(r_cc) + 66'(r_tl) + 66'(r_ts));
    assign w_acc_base = (i_cmd.op == OP_ACCY) ? r_sum_y : r_sum_x;
    assign w_acc      = sat_to40(66'(w_acc_base) + 66'(shr_frac(r_prod)));
    assign w_sfx      = sat_to32(66'(r_sum_x));
    assign w_sfy      = sat_to32(66'(r_sum_y));
    assign w_mag      = (r_len2 + $unsigned(r_prod)) >> FRAC_BITS;

    // configuration and control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_dist  <= 31'd66;
            r_thr       <= 32'd1;
            r_sum_x     <= '0;
            r_sum_y     <= '0;
            r_clip      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_MIN_DIST:  r_min_dist <= i_cfg_data[30:0];
                    REG_THRESHOLD: r_thr      <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.op == OP_EMIT) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (i_cmd.op)
                OP_LOAD: begin
                    if (i_in_data.source_present && (w_sdx.clip || w_sdy.clip)) begin
                        r_clip <= 1'b1;
                    end
                end
                OP_DIV_WB: begin
                    if (i_cmd.div_sel != DIV_UX && i_cmd.div_sel != DIV_UY && w_sq.clip) begin
                        r_clip <= 1'b1;
                    end
                end
                OP_GAIN: begin
                    if (w_gain.clip) r_clip <= 1'b1;
                end
                OP_MULY: begin
                    r_sum_x <= w_acc.val;
                    if (w_acc.clip) r_clip <= 1'b1;
                end
                OP_ACCY: begin
                    r_sum_y <= w_acc.val;
                    if (w_acc.clip) r_clip <= 1'b1;
                end
                OP_FSAT: begin
                    if (w_sfx.clip || w_sfy.clip) r_clip <= 1'b1;
                end
                OP_EMIT: begin
                    r_sum_x <= '0;
                    r_sum_y <= '0;
                    r_clip  <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_dx <= w_sdx.val;
                r_dy <= w_sdy.val;
                r_cc <= i_in_data.coef_constant;
                r_cl <= i_in_data.coef_linear;
                r_cs <= i_in_data.coef_square;
            end
            OP_SQX:  r_prod <= w_prod;
            OP_SQY: begin
                r_prod <= w_prod;
                r_len2 <= $unsigned(r_prod);
            end
            OP_LEN2: r_len2 <= r_len2 + $unsigned(r_prod);
            OP_DSET: begin
                r_len <= w_root;
                r_d   <= (w_root < w_md) ? w_md : w_root;
            end
            OP_DIV_WB: begin
                case (i_cmd.div_sel)
                    DIV_UX:  r_ux <= w_quo[31:0];
                    DIV_UY:  r_uy <= w_quo[31:0];
                    DIV_TL:  r_tl <= w_sq.val;
                    DIV_Q:   r_q  <= w_sq.val;
                    DIV_TS:  r_ts <= w_sq.val;
                    default: ;
                endcase
            end
            OP_GAIN: r_g    <= w_gain.val;
            OP_MULX: r_prod <= w_prod;
            OP_MULY: r_prod <= w_prod;
            OP_FSAT: begin
                r_fx <= w_sfx.val;
                r_fy <= w_sfy.val;
            end
            OP_FSQX: r_prod <= w_prod;
            OP_FSQY: begin
                r_prod <= w_prod;
                r_len2 <= $unsigned(r_prod);
            end
            OP_EMIT: begin
                r_out.force_x     <= r_fx;
                r_out.force_y     <= r_fy;
                r_out.significant <= (w_mag > {32'd0, r_thr});
                r_out.saturated   <= r_clip;
            end
            default: ;
        endcase
    end

    assign o_sts.len2_zero = (r_len2 == '0);
    assign o_sts.sqrt_done = w_sqrt_done;
    assign o_sts.div_done  = w_div_done;
    assign o_sts.out_free  = !r_out_valid || i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_out_data      = r_out;

endmodule

/* hw/rtl/radial_attraction_accumulator.sv */
`timescale 1ns / 1ps
// a present source with non-zero offset has its offsets squared, summed and checked
// for zero, then a bit-serial square root, five divisions on the one shared divider
// and gain and accumulation run before the next source is accepted; an absent source
// or a zero offset skips these steps; the last transaction of a set then saturates
// the sums, squares both forces and emits the result once the output register is free
// synchronous active-low reset clears sums and flags and sets configuration defaults
// ----------------------------------------------------------------------------
// radial_attraction_accumulator
// sums planar attraction of a set of sources on one body, Q16.16 saturating
// ----------------------------------------------------------------------------
module radial_attraction_accumulator import rac_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // source transactions
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in         i_in_data,
    // result transactions
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out        o_out_data,
    // configuration writes
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [31:0] i_cfg_data
);

    t_cmd w_cmd;
    t_sts w_sts;

    // sequencer: one operation a cycle, waits on input, the iterative units and the output register
    rac_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_present  (i_in_data.source_present),
        .i_last     (i_in_data.last_source),
        .i_sts      (w_sts),
        .o_in_ready (o_in_ready),
        .o_cmd      (w_cmd)
    );

    // datapath holds the sums, the configuration and the output register,
    // so a finished result can wait while the next transaction is taken
    rac_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (w_cmd),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (i_out_ready),
        .o_sts       (w_sts),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

`ifndef SYNTHESIS
    // a result is only written into a free output register
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.op == OP_EMIT |-> (!o_out_valid || i_out_ready))
        else $error("result written over a pending transaction");

    // a written result shows up as valid
    a_emit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.op == OP_EMIT |=> o_out_valid)
        else $error("result lost after write");

    // no new source while the square root finishes
    a_sqrt_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sts.sqrt_done |-> !o_in_ready)
        else $error("input taken during square root");

    // no new source while a division finishes
    a_div_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sts.div_done |-> !o_in_ready)
        else $error("input taken during division");
`endif

endmodule
